// File: rtl/core/tts_pkg.sv
`timescale 1ns / 1ps

package tts_pkg;

  typedef logic [1:0] vidx_t;

  localparam vidx_t IDX_A = 2'd0;
  localparam vidx_t IDX_B = 2'd1;
  localparam vidx_t IDX_C = 2'd2;

  typedef logic [1:0] tcnt_t;

  localparam tcnt_t CNT_NONE = 2'd0;
  localparam tcnt_t CNT_ONE  = 2'd1;
  localparam tcnt_t CNT_TWO  = 2'd2;

  typedef logic signed [15:0] coord_t;
  typedef logic signed [16:0] diff_t;
  typedef logic signed [33:0] prod_t;

  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t b_x;
    coord_t b_y;
    coord_t c_x;
    coord_t c_y;
  } vtx_req_t;

  typedef struct packed {
    tcnt_t  trap_count;
    coord_t top_y;
    coord_t bottom_y;
    vidx_t  left_from;
    vidx_t  left_to;
    vidx_t  right_from;
    vidx_t  right_to;
    logic   last;
  } trap_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    vidx_t  idx;
  } vert_t;

  typedef struct packed {
    logic rej;
    logic flat_top;
    logic flat_bot;
    logic swap_top;
    logic swap_bot;
  } cls_t;

  typedef struct packed {
    coord_t y1;
    coord_t y2;
    coord_t y3;
    vidx_t  p1;
    vidx_t  p2;
    vidx_t  p3;
    cls_t   cls;
  } tail_t;

endpackage

// File: rtl/core/tts_vtx_if.sv
`timescale 1ns / 1ps

interface tts_vtx_if;
  logic               valid;
  logic               ready;
  tts_pkg::vtx_req_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/tts_trap_if.sv
`timescale 1ns / 1ps

interface tts_trap_if;
  logic            valid;
  logic            ready;
  tts_pkg::trap_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/triangle_trapezoid_split.sv
`timescale 1ns / 1ps

// Channel   Dir  Request                       Per triangle
// vtx_i     in   a_x a_y b_x b_y c_x c_y       one
// trap_o    out  trapezoid bounds and edges    one or two, last on the final
//
// Four register stages: sort by y, differences and classification, the two
// cross products, then result build into the output register.
// A triangle enters every cycle unless the output stalls or a general triangle
// holds the output register until both of its results are taken. A request
// passes the sort, difference and product registers before the output register.
// Reset clears the stage valid bits and the result phase only.
// Each stage moves on when the next is empty or moving, so a stall on the
// output backs up stage by stage without losing or repeating a request.

module triangle_trapezoid_split (
  input  logic        clk_i,
  input  logic        rst_ni,
  tts_vtx_if.sink     vtx_i,
  tts_trap_if.source  trap_o
);
  import tts_pkg::*;

  // Stage 1: sorted vertices
  logic  s1_valid_q;
  vert_t s1_v_q [3];
  // Stage 2: differences and classification
  logic  s2_valid_q;
  diff_t s2_dx21_q, s2_dy31_q, s2_dx31_q, s2_dy21_q;
  tail_t s2_tail_q;
  // Stage 3: cross products
  logic  s3_valid_q;
  prod_t s3_lhs_q, s3_rhs_q;
  tail_t s3_tail_q;
  // Stage 4: output register
  logic  e_valid_q;
  logic  e_phase_q;
  trap_t e_r0_q, e_r1_q;

  logic  s1_rdy, s2_rdy, s3_rdy, e_rdy;
  logic  e_last;
  vert_t v0, v1, v2, t0;
  tail_t tail_d;
  trap_t r0_d, r1_d;
  logic  left_mid;

  assign e_last = e_phase_q || e_r0_q.last;
  assign e_rdy  = !e_valid_q || (trap_o.ready && e_last);
  assign s3_rdy = !s3_valid_q || e_rdy;
  assign s2_rdy = !s2_valid_q || s3_rdy;
  assign s1_rdy = !s1_valid_q || s2_rdy;
  assign vtx_i.ready = s1_rdy;

  // Three strict compare-and-swap steps sort by y; equal y is not always kept in input order.
  always_comb begin
    v0 = '{x: vtx_i.data.a_x, y: vtx_i.data.a_y, idx: IDX_A};
    v1 = '{x: vtx_i.data.b_x, y: vtx_i.data.b_y, idx: IDX_B};
    v2 = '{x: vtx_i.data.c_x, y: vtx_i.data.c_y, idx: IDX_C};
    if (v0.y > v1.y) begin
      t0 = v0; v0 = v1; v1 = t0;
    end
    if (v0.y > v2.y) begin
      t0 = v0; v0 = v2; v2 = t0;
    end
    if (v1.y > v2.y) begin
      t0 = v1; v1 = v2; v2 = t0;
    end else begin
      t0 = v1;
    end
  end

  always_comb begin
    tail_d.y1 = s1_v_q[0].y;
    tail_d.y2 = s1_v_q[1].y;
    tail_d.y3 = s1_v_q[2].y;
    tail_d.p1 = s1_v_q[0].idx;
    tail_d.p2 = s1_v_q[1].idx;
    tail_d.p3 = s1_v_q[2].idx;
    tail_d.cls.rej = (s1_v_q[0].y == s1_v_q[1].y && s1_v_q[0].y == s1_v_q[2].y) ||
                     (s1_v_q[0].x == s1_v_q[1].x && s1_v_q[0].x == s1_v_q[2].x);
    tail_d.cls.flat_top = (s1_v_q[0].y == s1_v_q[1].y);
    tail_d.cls.flat_bot = (s1_v_q[1].y == s1_v_q[2].y);
    tail_d.cls.swap_top = (s1_v_q[0].x > s1_v_q[1].x);
    tail_d.cls.swap_bot = (s1_v_q[1].x > s1_v_q[2].x);
  end

  // Result build. The middle vertex sits on the left when lhs <= rhs.
  always_comb begin
    left_mid = (s3_lhs_q <= s3_rhs_q);
    r0_d = '0;
    r1_d = '0;
    r0_d.last = 1'b1;
    r1_d.last = 1'b1;
    if (s3_tail_q.cls.rej) begin
      r0_d.trap_count = CNT_NONE;
    end else if (s3_tail_q.cls.flat_top) begin
      r0_d.trap_count = CNT_ONE;
      r0_d.top_y      = s3_tail_q.y1;
      r0_d.bottom_y   = s3_tail_q.y3;
      r0_d.left_from  = s3_tail_q.cls.swap_top ? s3_tail_q.p2 : s3_tail_q.p1;
      r0_d.right_from = s3_tail_q.cls.swap_top ? s3_tail_q.p1 : s3_tail_q.p2;
      r0_d.left_to    = s3_tail_q.p3;
      r0_d.right_to   = s3_tail_q.p3;
    end else if (s3_tail_q.cls.flat_bot) begin
      r0_d.trap_count = CNT_ONE;
      r0_d.top_y      = s3_tail_q.y1;
      r0_d.bottom_y   = s3_tail_q.y3;
      r0_d.left_from  = s3_tail_q.p1;
      r0_d.right_from = s3_tail_q.p1;
      r0_d.left_to    = s3_tail_q.cls.swap_bot ? s3_tail_q.p3 : s3_tail_q.p2;
      r0_d.right_to   = s3_tail_q.cls.swap_bot ? s3_tail_q.p2 : s3_tail_q.p3;
    end else begin
      r0_d.trap_count = CNT_TWO;
      r0_d.top_y      = s3_tail_q.y1;
      r0_d.bottom_y   = s3_tail_q.y2;
      r0_d.left_from  = s3_tail_q.p1;
      r0_d.right_from = s3_tail_q.p1;
      r0_d.left_to    = left_mid ? s3_tail_q.p2 : s3_tail_q.p3;
      r0_d.right_to   = left_mid ? s3_tail_q.p3 : s3_tail_q.p2;
      r0_d.last       = 1'b0;
      r1_d.trap_count = CNT_TWO;
      r1_d.top_y      = s3_tail_q.y2;
      r1_d.bottom_y   = s3_tail_q.y3;
      r1_d.left_from  = left_mid ? s3_tail_q.p2 : s3_tail_q.p1;
      r1_d.right_from = left_mid ? s3_tail_q.p1 : s3_tail_q.p2;
      r1_d.left_to    = s3_tail_q.p3;
      r1_d.right_to   = s3_tail_q.p3;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      e_valid_q  <= 1'b0;
      e_phase_q  <= 1'b0;
    end else begin
      if (s1_rdy) s1_valid_q <= vtx_i.valid;
      if (s2_rdy) s2_valid_q <= s1_valid_q;
      if (s3_rdy) s3_valid_q <= s2_valid_q;
      if (e_rdy) begin
        e_valid_q <= s3_valid_q;
        e_phase_q <= 1'b0;
      end else if (trap_o.ready) begin
        e_phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && vtx_i.valid) begin
      s1_v_q[0] <= v0;
      s1_v_q[1] <= v1;
      s1_v_q[2] <= v2;
    end
    if (s2_rdy && s1_valid_q) begin
      s2_dx21_q <= diff_t'(s1_v_q[1].x) - diff_t'(s1_v_q[0].x);
      s2_dy31_q <= diff_t'(s1_v_q[2].y) - diff_t'(s1_v_q[0].y);
      s2_dx31_q <= diff_t'(s1_v_q[2].x) - diff_t'(s1_v_q[0].x);
      s2_dy21_q <= diff_t'(s1_v_q[1].y) - diff_t'(s1_v_q[0].y);
      s2_tail_q <= tail_d;
    end
    if (s3_rdy && s2_valid_q) begin
      s3_lhs_q  <= s2_dx21_q * s2_dy31_q;
      s3_rhs_q  <= s2_dx31_q * s2_dy21_q;
      s3_tail_q <= s2_tail_q;
    end
    if (e_rdy && s3_valid_q) begin
      e_r0_q <= r0_d;
      e_r1_q <= r1_d;
    end
  end

  assign trap_o.valid = e_valid_q;
  assign trap_o.data  = e_phase_q ? e_r1_q : e_r0_q;

  // The second result is only ever shown for a two-trapezoid triangle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_phase_q |-> (e_valid_q && e_r0_q.trap_count == CNT_TWO))
    else $error("second result shown for a single-result triangle");

  // A taken first result is followed directly by its final result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (trap_o.valid && trap_o.ready && !trap_o.data.last) |=>
      (trap_o.valid && trap_o.data.last && trap_o.data.trap_count == CNT_TWO))
    else $error("final result missing after first of two");

  // Only a general triangle leaves a result that is not the last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (trap_o.valid && !trap_o.data.last) |-> (trap_o.data.trap_count == CNT_TWO))
    else $error("non-final result with count other than two");

  // A rejected triangle reports all-zero bounds and edges.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (trap_o.valid && trap_o.data.trap_count == CNT_NONE) |->
      (trap_o.data.last && trap_o.data.top_y == '0 && trap_o.data.bottom_y == '0 &&
       trap_o.data.left_from == IDX_A && trap_o.data.right_to == IDX_A))
    else $error("rejected triangle result not cleared");

endmodule
